// File: hw/rtl/rbs_pkg.sv
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared widths, operation codes and controller/datapath signal groups for
// the bit vector rank/select unit.
// ----------------------------------------------------------------------------
package rbs_pkg;

  localparam int VECTOR_BITS_DEF = 1024;

  localparam int OP_W   = 2;
  localparam int ADDR_W = 7;
  localparam int BYTE_W = 8;
  localparam int POS_W  = 11;
  localparam int BN_W   = POS_W - 3;

  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_RANK   = 2'd1;
  localparam logic [OP_W-1:0] OP_SELECT = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  localparam logic [BYTE_W-1:0] BYTE_ONES = 8'd255;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] byte_addr;
    logic [BYTE_W-1:0] byte_value;
    logic [POS_W-1:0]  range_start;
    logic [POS_W-1:0]  range_end;
    logic [POS_W-1:0]  occurrence;
    logic              match_bit;
  } in_item_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic move;
  } dp_cmd_t;

  typedef struct packed {
    logic in_query;
    logic fin;
  } dp_sts_t;

endpackage

// File: hw/rtl/rbs_in_if.sv
// ----------------------------------------------------------------------------
// rbs_in_if
// Input channel of the rank/select unit: valid/ready plus one item.
// ----------------------------------------------------------------------------
interface rbs_in_if import rbs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [ADDR_W-1:0] byte_addr;
  logic [BYTE_W-1:0] byte_value;
  logic [POS_W-1:0]  range_start;
  logic [POS_W-1:0]  range_end;
  logic [POS_W-1:0]  occurrence;
  logic              match_bit;

  modport source (
    output valid, op, byte_addr, byte_value, range_start, range_end, occurrence,
           match_bit,
    input  ready
  );
  modport sink (
    input  valid, op, byte_addr, byte_value, range_start, range_end, occurrence,
           match_bit,
    output ready
  );
endinterface

// File: hw/rtl/rbs_out_if.sv
// ----------------------------------------------------------------------------
// rbs_out_if
// Result channel of the rank/select unit: valid/ready plus answer and flag.
// ----------------------------------------------------------------------------
interface rbs_out_if import rbs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] answer;
  logic             found;

  modport source (output valid, answer, found, input ready);
  modport sink (input valid, answer, found, output ready);
endinterface

// File: hw/rtl/rbs_ctrl.sv
// ----------------------------------------------------------------------------
// rbs_ctrl
// Sequencer: takes transactions, runs one query scan at a time and hands
// finished results to the output register.
// ----------------------------------------------------------------------------
module rbs_ctrl import rbs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_vld_q, out_vld_d;
  logic       in_fire, out_fire, slot_free;

  assign in_fire   = in_valid_i && in_ready_o;
  assign out_fire  = out_vld_q && out_ready_i;
  assign slot_free = !out_vld_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        if (in_fire && sts_i.in_query) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.fin) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        // result sits in the datapath until the output register frees up
        if (slot_free) begin
          cmd_o.move = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.move) begin
      out_vld_d = 1'b1;
    end else if (out_fire) begin
      out_vld_d = 1'b0;
    end
  end

  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

// File: hw/rtl/rbs_datapath.sv
// ----------------------------------------------------------------------------
// rbs_datapath
// Byte store, length register, range clipping and the byte-wise scan that
// counts matching bits and locates the k-th one.
// ----------------------------------------------------------------------------
module rbs_datapath import rbs_pkg::*; #(
  parameter int VECTOR_BITS = VECTOR_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [POS_W-1:0] cfg_data_i,
  input  in_item_t         item_i,
  input  dp_cmd_t          cmd_i,
  output dp_sts_t          sts_o,
  output logic [POS_W-1:0] answer_o,
  output logic             found_o
);

  localparam int StoreBytes = VECTOR_BITS / 8;
  localparam int AW         = (StoreBytes > 1) ? $clog2(StoreBytes) : 1;
  localparam int CapInt     = (VECTOR_BITS < 2047) ? VECTOR_BITS : 2047;
  localparam logic [POS_W-1:0] LenCap = POS_W'(CapInt);

  logic [BYTE_W-1:0] mem [StoreBytes];

  logic [POS_W-1:0]  bit_length_q;
  logic              dat_vld_q;
  logic [BYTE_W-1:0] rd_data_q;
  logic [BN_W-1:0]   dat_bn_q;
  logic [BN_W:0]     rd_bn_q;
  logic [BN_W-1:0]   first_bn_q, last_bn_q;
  logic [2:0]        first_lo_q, last_hi_q;
  logic              empty_q, sel_q, want_q;
  logic [POS_W-1:0]  occ_q, count_q;
  logic [POS_W-1:0]  res_ans_q, out_ans_q;
  logic              res_found_q, out_found_q;

  logic [POS_W-1:0]  eff_len, st, en, en_m1;
  logic              wr_ok, issue;
  logic [BYTE_W-1:0] bits, lo_mask, hi_mask, hits;
  logic [3:0]        pop, need, run;
  logic [POS_W:0]    total;
  logic              hit, last_byte, fin, seen;
  logic [2:0]        sel_j;
  logic [POS_W-1:0]  fin_ans;
  logic              fin_found;

  // clip the query range to the loaded length
  always_comb begin
    eff_len = (bit_length_q > LenCap) ? LenCap : bit_length_q;
    st      = (item_i.range_start > eff_len) ? eff_len : item_i.range_start;
    en      = (item_i.range_end > eff_len) ? eff_len : item_i.range_end;
    en_m1   = en - POS_W'(1);
  end

  assign wr_ok = (32'(item_i.byte_addr) < StoreBytes);
  assign issue = cmd_i.scan && !empty_q && (rd_bn_q <= {1'b0, last_bn_q});

  // per-byte count and k-th bit search
  always_comb begin
    bits    = want_q ? rd_data_q : ~rd_data_q;
    lo_mask = (dat_bn_q == first_bn_q) ? (BYTE_ONES << first_lo_q) : BYTE_ONES;
    hi_mask = (dat_bn_q == last_bn_q) ? (BYTE_ONES >> (3'd7 - last_hi_q)) : BYTE_ONES;
    hits    = bits & lo_mask & hi_mask;
    pop     = 4'($countones(hits));
    total   = {1'b0, count_q} + (POS_W+1)'(pop);
    hit     = sel_q && (occ_q != '0) && (total >= {1'b0, occ_q});
    need    = 4'(occ_q - count_q);
    run     = '0;
    seen    = 1'b0;
    sel_j   = '0;
    for (int j = 0; j < BYTE_W; j++) begin
      if (hits[j] && !seen) begin
        run = run + 4'd1;
        if (run == need) begin
          seen  = 1'b1;
          sel_j = 3'(j);
        end
      end
    end
    last_byte = (dat_bn_q == last_bn_q);
    fin       = cmd_i.scan && (empty_q || (dat_vld_q && (hit || last_byte)));
    if (empty_q) begin
      fin_ans   = '0;
      fin_found = !sel_q;
    end else if (hit) begin
      fin_ans   = POS_W'({dat_bn_q, sel_j});
      fin_found = 1'b1;
    end else begin
      fin_ans   = total[POS_W-1:0];
      fin_found = !sel_q;
    end
  end

  assign sts_o.in_query = (item_i.op == OP_RANK) || (item_i.op == OP_SELECT);
  assign sts_o.fin      = fin;
  assign answer_o       = out_ans_q;
  assign found_o        = out_found_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (item_i.op == OP_WRITE) && wr_ok) begin
      mem[AW'(item_i.byte_addr)] <= item_i.byte_value;
    end
    if (issue) begin
      rd_data_q <= mem[AW'(rd_bn_q)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_length_q <= '0;
      dat_vld_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        bit_length_q <= cfg_data_i;
      end
      dat_vld_q <= cmd_i.load ? 1'b0 : issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      first_bn_q <= st[POS_W-1:3];
      first_lo_q <= st[2:0];
      last_bn_q  <= en_m1[POS_W-1:3];
      last_hi_q  <= en_m1[2:0];
      rd_bn_q    <= {1'b0, st[POS_W-1:3]};
      empty_q    <= (st >= en);
      sel_q      <= (item_i.op == OP_SELECT);
      want_q     <= item_i.match_bit;
      occ_q      <= item_i.occurrence;
      count_q    <= '0;
    end else begin
      if (issue) begin
        rd_bn_q  <= rd_bn_q + (BN_W+1)'(1);
        dat_bn_q <= rd_bn_q[BN_W-1:0];
      end
      if (cmd_i.scan && dat_vld_q) begin
        count_q <= total[POS_W-1:0];
      end
    end
    if (fin) begin
      res_ans_q   <= fin_ans;
      res_found_q <= fin_found;
    end
    if (cmd_i.move) begin
      out_ans_q   <= res_ans_q;
      out_found_q <= res_found_q;
    end
  end

endmodule

// File: hw/rtl/bitvector_rank_select_unit.sv
// ----------------------------------------------------------------------------
// bitvector_rank_select_unit
// Bit vector held in a byte store with rank (count of matching bits over a
// range) and select (position of the k-th matching bit) queries.
// ----------------------------------------------------------------------------
// A write transaction stores one byte. A rank or select transaction scans
// the range a byte at a time through the single read port of the byte
// store; select stops at the byte that holds its bit, and an empty range
// reads no bytes. One query is worked on at a time, but a new transaction
// is taken while the previous result still waits on the output. The user
// must write bit_length through cfg_we_i/cfg_data_i only while the unit is
// idle, which the block itself does not enforce; bytes never written read
// as unknown.
module bitvector_rank_select_unit import rbs_pkg::*; #(
  parameter int VECTOR_BITS = VECTOR_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [POS_W-1:0] cfg_data_i,
  rbs_in_if.sink           item_i,
  rbs_out_if.source        result_o
);

  in_item_t item;
  dp_cmd_t  cmd;
  dp_sts_t  sts;

  assign item.op          = item_i.op;
  assign item.byte_addr   = item_i.byte_addr;
  assign item.byte_value  = item_i.byte_value;
  assign item.range_start = item_i.range_start;
  assign item.range_end   = item_i.range_end;
  assign item.occurrence  = item_i.occurrence;
  assign item.match_bit   = item_i.match_bit;

  rbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rbs_datapath #(
    .VECTOR_BITS (VECTOR_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .answer_o   (result_o.answer),
    .found_o    (result_o.found)
  );

endmodule
